[src/scc_pkg.sv]
// Shared constants and helpers for the sensor channel conditioner.
`default_nettype none
package scc_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] REG_RES_BITS  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_FILT_MASK = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_SCALE_MIN = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_SCALE_MAX = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_ALARM_LO  = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_ALARM_HI  = 3'd5;

  localparam int unsigned MaxRes = 24;
  localparam int unsigned InDataW = 32;
  localparam int unsigned OutDataW = 232;

  // Saturate a wide signed value onto the signed 32-bit range.
  function automatic logic signed [31:0] clamp32(input logic signed [65:0] x);
    logic signed [31:0] r;
    if (x > 66'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (x < -66'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[src/sensor_channel_conditioner_unit.sv]
// Sensor channel conditioner: scaling, IIR, min/max/mean/RMS and alarm statistics.
//
//  channel   dir  fields (tdata, lowest bit first)
//  s_axis    in   channel[2:0], raw_sample[27:3]
//  m_axis    out  channel_out, value, saturated, alarm, alarm_above, min_seen,
//                 max_seen, mean_value, rms_value, sample_total, alarm_total
//  cfg       in   cfg_we_i, cfg_idx_i, cfg_wdata_i
//
// Samples are taken only in S_IDLE, and each runs through to S_OUT before the next
// is accepted; the filter adds the S_FILT and S_FSTEP states. The run is set by the
// 34-step serial divider for the mean and the 32-step square root.
// One 32x32 multiplier serves scaling, the divide by ten and both squares.
// Reset clears all per-channel state at once; no clearing pass.
// s_axis_tready is high only when the sequencer is idle; a held result does
// not block the next sample, only the next result write.
`default_nettype none
module sensor_channel_conditioner_unit
  import scc_pkg::*;
#(
  parameter int unsigned CHANNELS = 8
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [InDataW-1:0]  s_axis_tdata,   // channel, raw_sample, zero pad
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [OutDataW-1:0]      m_axis_tdata,   // channel_out, value, saturated, alarm,
                                                   // alarm_above, min_seen, max_seen,
                                                   // mean_value, rms_value, sample_total,
                                                   // alarm_total, zero pad
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MULSC = 4'd1;
  localparam logic [3:0] S_SCALE = 4'd2;
  localparam logic [3:0] S_DIV   = 4'd3;
  localparam logic [3:0] S_FILT  = 4'd4;
  localparam logic [3:0] S_STATS = 4'd5;
  localparam logic [3:0] S_MEAN  = 4'd6;
  localparam logic [3:0] S_SQR   = 4'd7;
  localparam logic [3:0] S_SQA   = 4'd8;
  localparam logic [3:0] S_SQSUM = 4'd9;
  localparam logic [3:0] S_SQRT  = 4'd10;
  localparam logic [3:0] S_OUT   = 4'd11;
  localparam logic [3:0] S_FSTEP = 4'd12;

  // ceil(2^34 / 5): exact x/5 for any 32-bit x after a 34-bit shift
  localparam logic [31:0] RECIP5 = 32'hCCCCCCCD;

  // configuration
  logic [4:0]         res_q;
  logic [7:0]         fmask_q;
  logic signed [31:0] smin_q, smax_q, alo_q, ahi_q;

  // per-channel state
  logic signed [31:0] acc_q  [CHANNELS];
  logic signed [31:0] min_q  [CHANNELS];
  logic signed [31:0] max_q  [CHANNELS];
  logic signed [31:0] mean_q [CHANNELS];
  logic [31:0]        rms_q  [CHANNELS];
  logic [31:0]        cnt_q  [CHANNELS];
  logic [31:0]        acnt_q [CHANNELS];

  logic [3:0]          state_q;
  logic [2:0]          ch_q;
  logic signed [24:0]  raw_q;
  logic signed [31:0]  v_q;
  logic                sat_q, alarm_q, above_q;
  logic                neg_q;
  logic [63:0]         prod_q;
  logic [63:0]         sqa_q;
  logic [33:0]         div_n_q, div_quo_q;
  logic [31:0]         div_d_q, div_rem_q;
  logic [5:0]          div_cnt_q;
  logic [63:0]         sq_n_q;
  logic [33:0]         sq_rem_q;
  logic [31:0]         sq_root_q;
  logic [4:0]          sq_cnt_q;

  logic [4:0] bits;
  always_comb begin
    bits = res_q;
    if (res_q == 5'd0) bits = 5'd1;
    if (res_q > 5'(MaxRes)) bits = 5'(MaxRes);
  end

  // filter difference, rounded half away from zero: (|d| + 5) / 10 = ((|d| + 5) >> 1) / 5
  logic signed [32:0] fd;
  logic [32:0]        fd_mag;
  logic [32:0]        fd_rnd;
  assign fd     = {v_q[31], v_q} - {acc_q[ch_q][31], acc_q[ch_q]};
  assign fd_mag = fd[32] ? 33'(-fd) : 33'(fd);
  assign fd_rnd = fd_mag + 33'd5;

  // shared multiplier operand selection
  logic signed [32:0] diff;
  logic [31:0]        diff_mag;
  logic [24:0]        raw_mag;
  logic [31:0]        v_mag;
  logic [31:0]        mul_a, mul_b;
  assign diff     = {smax_q[31], smax_q} - {smin_q[31], smin_q};
  assign diff_mag = diff[32] ? 32'(-diff) : diff[31:0];
  assign raw_mag  = raw_q[24] ? 25'(-raw_q) : raw_q;
  assign v_mag    = v_q[31] ? 32'(-v_q) : v_q;

  always_comb begin
    case (state_q)
      S_MULSC: begin mul_a = {7'd0, raw_mag}; mul_b = diff_mag; end
      S_FILT:  begin mul_a = fd_rnd[32:1]; mul_b = RECIP5; end
      S_SQR:   begin mul_a = rms_q[ch_q]; mul_b = rms_q[ch_q]; end
      default: begin mul_a = v_mag; mul_b = v_mag; end
    endcase
  end

  // scaled value from the registered product
  logic signed [64:0] sprod, sshift;
  logic signed [65:0] ssum;
  assign sprod  = neg_q ? -$signed({1'b0, prod_q}) : $signed({1'b0, prod_q});
  assign sshift = sprod >>> bits;
  assign ssum   = {sshift[64], sshift} + 66'(smin_q);

  // mean difference
  logic signed [32:0] md;
  logic [32:0]        md_mag;
  assign md     = {v_q[31], v_q} - {mean_q[ch_q][31], mean_q[ch_q]};
  assign md_mag = md[32] ? 33'(-md) : 33'(md);

  logic [31:0] cnt_inc;
  assign cnt_inc = (cnt_q[ch_q] == 32'hffffffff) ? cnt_q[ch_q] : cnt_q[ch_q] + 32'd1;

  // divider step
  logic [32:0] div_t;
  logic        div_ge;
  assign div_t  = {div_rem_q, div_n_q[33]};
  assign div_ge = div_t >= {1'b0, div_d_q};

  // square root step
  logic [35:0] sq_t;
  logic [35:0] sq_trial;
  logic        sq_ge;
  assign sq_t     = {sq_rem_q, sq_n_q[63:62]};
  assign sq_trial = {2'b00, sq_root_q, 2'b01};
  assign sq_ge    = sq_t >= sq_trial;

  logic signed [30:0] fstep;
  logic signed [33:0] mstep;
  assign fstep = neg_q ? -$signed({1'b0, prod_q[63:34]}) : $signed({1'b0, prod_q[63:34]});
  assign mstep = neg_q ? -$signed(div_quo_q) : $signed(div_quo_q);

  logic v_lo, v_hi;
  assign v_hi = v_q > ahi_q;
  assign v_lo = v_q < alo_q;

  logic [64:0] sq_sum;
  assign sq_sum = {1'b0, sqa_q} + {1'b0, prod_q};

  logic [24:0] max_raw;
  assign max_raw = 25'((33'd1 << bits) - 33'd1);

  assign s_axis_tready = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q   <= 5'd12;
      fmask_q <= 8'd0;
      smin_q  <= 32'sd0;
      smax_q  <= 32'sd65536;
      alo_q   <= 32'sh80000000;
      ahi_q   <= 32'sh7fffffff;
      state_q <= S_IDLE;
      m_axis_tvalid <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        acc_q[c]  <= '0;
        min_q[c]  <= '0;
        max_q[c]  <= '0;
        mean_q[c] <= '0;
        rms_q[c]  <= '0;
        cnt_q[c]  <= '0;
        acnt_q[c] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_RES_BITS:  res_q   <= cfg_wdata_i[4:0];
          REG_FILT_MASK: fmask_q <= cfg_wdata_i[7:0];
          REG_SCALE_MIN: smin_q  <= cfg_wdata_i;
          REG_SCALE_MAX: smax_q  <= cfg_wdata_i;
          REG_ALARM_LO:  alo_q   <= cfg_wdata_i;
          REG_ALARM_HI:  ahi_q   <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (state_q == S_OUT && (!m_axis_tvalid || m_axis_tready)) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            ch_q  <= s_axis_tdata[2:0];
            raw_q <= s_axis_tdata[27:3];
            // samples for channels beyond the configured count are dropped
            if (32'(s_axis_tdata[2:0]) < CHANNELS) state_q <= S_MULSC;
          end
        end
        S_MULSC: begin
          prod_q  <= mul_a * mul_b;
          neg_q   <= raw_q[24] ^ diff[32];
          state_q <= S_SCALE;
        end
        S_SCALE: begin
          v_q <= clamp32(ssum);
          if (fmask_q[ch_q]) begin
            state_q <= S_FILT;
          end else begin
            state_q <= S_STATS;
          end
        end
        S_FILT: begin
          prod_q  <= mul_a * mul_b;
          neg_q   <= fd[32];
          state_q <= S_FSTEP;
        end
        S_FSTEP: begin
          acc_q[ch_q] <= clamp32(66'(acc_q[ch_q]) + 66'(fstep));
          v_q         <= clamp32(66'(acc_q[ch_q]) + 66'(fstep));
          state_q     <= S_STATS;
        end
        S_DIV: begin
          div_n_q   <= {div_n_q[32:0], 1'b0};
          div_quo_q <= {div_quo_q[32:0], div_ge};
          div_rem_q <= div_ge ? 32'(div_t - {1'b0, div_d_q}) : div_t[31:0];
          div_cnt_q <= div_cnt_q - 6'd1;
          if (div_cnt_q == 6'd1) begin
            state_q <= S_MEAN;
          end
        end
        S_STATS: begin
          if (cnt_q[ch_q] == 32'd0) begin
            min_q[ch_q] <= v_q;
            max_q[ch_q] <= v_q;
          end else begin
            if (v_q < min_q[ch_q]) min_q[ch_q] <= v_q;
            if (v_q > max_q[ch_q]) max_q[ch_q] <= v_q;
          end
          cnt_q[ch_q] <= cnt_inc;
          sat_q   <= (raw_q <= 25'sd0) || (raw_q >= $signed(max_raw));
          above_q <= v_hi;
          alarm_q <= v_lo || v_hi;
          if ((v_lo || v_hi) && acnt_q[ch_q] != 32'hffffffff) begin
            acnt_q[ch_q] <= acnt_q[ch_q] + 32'd1;
          end
          div_n_q   <= {1'b0, md_mag};
          div_d_q   <= cnt_inc;
          div_rem_q <= '0;
          div_cnt_q <= 6'd34;
          neg_q     <= md[32];
          state_q   <= S_DIV;
        end
        S_MEAN: begin
          mean_q[ch_q] <= 32'(34'(mean_q[ch_q]) + mstep);
          state_q      <= S_SQR;
        end
        S_SQR: begin
          prod_q  <= mul_a * mul_b;
          state_q <= S_SQA;
        end
        S_SQA: begin
          sqa_q   <= prod_q;
          prod_q  <= mul_a * mul_b;
          state_q <= S_SQSUM;
        end
        S_SQSUM: begin
          sq_n_q    <= sq_sum[64:1];
          sq_rem_q  <= '0;
          sq_root_q <= '0;
          sq_cnt_q  <= 5'd31;
          state_q   <= S_SQRT;
        end
        S_SQRT: begin
          sq_n_q    <= {sq_n_q[61:0], 2'b00};
          sq_rem_q  <= sq_ge ? 34'(sq_t - sq_trial) : sq_t[33:0];
          sq_root_q <= {sq_root_q[30:0], sq_ge};
          sq_cnt_q  <= sq_cnt_q - 5'd1;
          if (sq_cnt_q == 5'd0) begin
            rms_q[ch_q] <= {sq_root_q[30:0], sq_ge};
            state_q     <= S_OUT;
          end
        end
        S_OUT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // result register, loaded with the transfer that leaves S_OUT
  always_ff @(posedge clk_i) begin
    if (state_q == S_OUT && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tdata <= {3'b000, acnt_q[ch_q], cnt_q[ch_q], rms_q[ch_q][30:0],
                       mean_q[ch_q], max_q[ch_q], min_q[ch_q],
                       above_q, alarm_q, sat_q, v_q, ch_q};
    end
  end

endmodule
`default_nettype wire
